// ===== rtl/core/sacache_pkg.sv =====
// Package for the set-associative cache hit model.
// Holds geometry constants, register indexes and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package sacache_pkg;

  localparam int MaxLinesLog2 = 8;
  localparam int StoreDepth   = 1 << MaxLinesLog2;
  localparam int SlotW        = MaxLinesLog2;
  localparam int TagW         = 31;
  localparam int CountW       = 32;
  localparam int AddrW        = 32;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 5;

  localparam logic [CfgIdxW-1:0] REG_LINES_LOG2     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LINE_SIZE_LOG2 = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WAYS_LOG2      = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_REPLACE_LRU    = 2'd3;

  typedef struct packed {
    logic load;      // capture the request and work out tag and set
    logic rd_nxt;    // read slot i+1 instead of slot i
    logic inc_i;     // advance the way counter
    logic clr_i;     // restart the way counter at slot 0
    logic wr_tag;    // write the request tag into slot i and mark it valid
    logic wr_shift;  // write the data just read into slot i
    logic set_hit;   // record a hit
    logic push;      // update counters and load the result register
  } sacache_cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic match;
    logic last;
    logic next_valid;
    logic lru;
    logic out_free;
  } sacache_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/sacache_req_if.sv =====
// Request channel interface: one byte address per transaction.
// Depends on sacache_pkg.
`default_nettype none

interface sacache_req_if import sacache_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sacache_rsp_if.sv =====
// Result channel interface: hit flag and running counts per transaction.
// Depends on sacache_pkg.
`default_nettype none

interface sacache_rsp_if import sacache_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [CountW-1:0] hit_count;
  logic [CountW-1:0] access_count;

  modport source (output valid, output hit, output hit_count, output access_count,
                  input ready);
  modport sink (input valid, input hit, input hit_count, input access_count,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sacache_ctrl.sv =====
// Sequencer for one lookup: scan the set, shift entries, write the tag.
// Depends on sacache_pkg.
`default_nettype none

module sacache_ctrl import sacache_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_ready,
  input  wire sacache_sts_t sts,
  output sacache_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CK   = 3'd2;
  localparam logic [2:0] ST_SCHK = 3'd3;
  localparam logic [2:0] ST_SWR  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: state_next = ST_CK;
      ST_CK: begin
        if (!sts.cur_valid) begin
          cmd.wr_tag = 1'b1;
          state_next = ST_DONE;
        end else if (sts.match) begin
          cmd.set_hit = 1'b1;
          state_next  = sts.lru ? ST_SCHK : ST_DONE;
        end else if (sts.last) begin
          // full set, no match: evict slot 0 by shifting from the front
          cmd.clr_i  = 1'b1;
          state_next = ST_SCHK;
        end else begin
          cmd.inc_i  = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_SCHK: begin
        if (!sts.last && sts.next_valid) begin
          cmd.rd_nxt = 1'b1;
          state_next = ST_SWR;
        end else begin
          cmd.wr_tag = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_SWR: begin
        cmd.wr_shift = 1'b1;
        cmd.inc_i    = 1'b1;
        state_next   = ST_SCHK;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sacache_dp.sv =====
// Datapath: configuration registers, tag memory, valid bits, way counter,
// running counts and the result register. Depends on sacache_pkg.
`default_nettype none

module sacache_dp import sacache_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic [AddrW-1:0]    address,
  input  wire sacache_cmd_t        cmd,
  output sacache_sts_t             sts,
  sacache_rsp_if.source            rsp
);

  logic [3:0]        lines_log2;
  logic [4:0]        line_size_log2;
  logic [3:0]        ways_log2;
  logic              replace_lru;

  logic [TagW-1:0]   tag;
  logic [SlotW-1:0]  base;
  logic [SlotW-1:0]  set_mask;
  logic [SlotW-1:0]  way;
  logic              hit;

  logic [TagW-1:0]   mem [StoreDepth];
  logic [TagW-1:0]   rdata;
  logic [StoreDepth-1:0] valid;

  logic [CountW-1:0] hits_total;
  logic [CountW-1:0] accesses_total;

  logic [3:0]        nl;
  logic [3:0]        nw;
  logic [SlotW-1:0]  lines_mask_new;
  logic [SlotW-1:0]  set_mask_new;
  logic [TagW-1:0]   tag_new;
  logic [SlotW-1:0]  cur_slot;
  logic [SlotW-1:0]  nxt_slot;
  logic [SlotW-1:0]  rd_slot;

  // clamp geometry and split the address
  always_comb begin
    nl             = (lines_log2 > 4'(MaxLinesLog2)) ? 4'(MaxLinesLog2) : lines_log2;
    nw             = (ways_log2 > nl) ? nl : ways_log2;
    lines_mask_new = SlotW'((9'd1 << nl) - 9'd1);
    set_mask_new   = SlotW'((9'd1 << nw) - 9'd1);
    tag_new        = TagW'(address >> line_size_log2);
  end

  assign cur_slot = base | way;
  assign nxt_slot = base | SlotW'(way + 1'b1);
  assign rd_slot  = cmd.rd_nxt ? nxt_slot : cur_slot;

  assign sts.cur_valid  = valid[cur_slot];
  assign sts.match      = (rdata == tag);
  assign sts.last       = (way == set_mask);
  assign sts.next_valid = valid[nxt_slot];
  assign sts.lru        = replace_lru;
  assign sts.out_free   = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_log2     <= 4'd8;
      line_size_log2 <= 5'd2;
      ways_log2      <= 4'd3;
      replace_lru    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINES_LOG2:     lines_log2     <= cfg_data[3:0];
        REG_LINE_SIZE_LOG2: line_size_log2 <= cfg_data[4:0];
        REG_WAYS_LOG2:      ways_log2      <= cfg_data[3:0];
        REG_REPLACE_LRU:    replace_lru    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag      <= tag_new;
      base     <= tag_new[SlotW-1:0] & lines_mask_new & ~set_mask_new;
      set_mask <= set_mask_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      way <= '0;
      hit <= 1'b0;
    end else begin
      if (cmd.load || cmd.clr_i) begin
        way <= '0;
      end else if (cmd.inc_i) begin
        way <= SlotW'(way + 1'b1);
      end
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (cmd.set_hit) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_tag) begin
      mem[cur_slot] <= tag;
    end else if (cmd.wr_shift) begin
      mem[cur_slot] <= rdata;
    end
    rdata <= mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.wr_tag) begin
      valid[cur_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_total     <= '0;
      accesses_total <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      if (cmd.push) begin
        hits_total     <= hits_total + CountW'(hit);
        accesses_total <= accesses_total + 1'b1;
        rsp.valid      <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp.hit          <= hit;
      rsp.hit_count    <= hits_total + CountW'(hit);
      rsp.access_count <= accesses_total + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_cache_hit_model_unit.sv =====
// Top level of the set-associative cache hit model.
// Depends on sacache_pkg, sacache_req_if, sacache_rsp_if, sacache_ctrl, sacache_dp.
//
// Usage:
//   req carries one byte address per transaction; rsp returns the hit flag
//   together with the running hit and access counts, the current one included.
//   Configuration is a plain write port: cfg_we, cfg_index (0 lines_log2,
//   1 line_size_log2, 2 ways_log2, 3 replace_lru) and cfg_data. Write it only
//   while no lookup is in flight.
//
// Sequence:
//   One lookup at a time. Each slot scanned takes a tag memory read step and
//   a compare step; a load step comes before the scan and a result hand-off
//   step after it. When a hit in LRU mode or an eviction rewrites the set,
//   each entry moved takes a check step and a shift-write step, and a final
//   tag write follows. The registered read of the tag memory sets this pace.
//
// Reset (rst, synchronous) restores the register defaults 8, 2, 3, FIFO,
// clears all valid bits at once and zeroes both counts; no clearing pass.
// The result register frees req while a result waits; if rsp stalls, a
// finished lookup holds in its last state until the register is free.
`default_nettype none

module set_assoc_cache_hit_model_unit import sacache_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  sacache_req_if.sink              req,
  sacache_rsp_if.source            rsp,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  sacache_cmd_t cmd;
  sacache_sts_t sts;

  // sequencer: scan, shift, write back
  sacache_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, counts and result register
  sacache_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .address   (req.address),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

  // one lookup at a time: an accepted request closes the request side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a lookup is in flight");

  // consecutive results count accesses by one
  a_access_step: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready |=>
      !rsp.valid || rsp.access_count == CountW'($past(rsp.access_count) + 1'b1))
    else $error("access count did not advance by one");

  // on a freshly loaded result, the hit count advances by that result's hit flag
  a_hit_step: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready |=>
      !rsp.valid ||
      rsp.hit_count == CountW'($past(rsp.hit_count) + CountW'(rsp.hit)))
    else $error("hit count inconsistent with hit flag");

endmodule

`default_nettype wire

// ===== test/sacache_tb_if.sv =====
// Testbench-side note: the channel interfaces come from the RTL
// (sacache_req_if, sacache_rsp_if); this file holds the hit-prediction scoreboard.
// Depends on sacache_pkg.
package sacache_tb_pkg;
  import sacache_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] hit_count;
    logic [CountW-1:0] access_count;
  } lookup_result_t;

  class hit_scoreboard;
    logic [3:0] lines_log2 = 4'd8;
    logic [4:0] line_size_log2 = 5'd2;
    logic [3:0] ways_log2 = 4'd3;
    bit replace_lru = 1'b0;
    logic [TagW-1:0] tags [StoreDepth];
    bit valid_bits [StoreDepth];
    logic [CountW-1:0] hits = '0;
    logic [CountW-1:0] accesses = '0;
    lookup_result_t pending [$];
    int mismatches = 0;

    function new();
      foreach (valid_bits[k]) begin
        valid_bits[k] = 1'b0;
        tags[k] = '0;
      end
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_LINES_LOG2:     lines_log2 = val[3:0];
        REG_LINE_SIZE_LOG2: line_size_log2 = val;
        REG_WAYS_LOG2:      ways_log2 = val[3:0];
        REG_REPLACE_LRU:    replace_lru = val[0];
        default: ;
      endcase
    endfunction

    // Search one set; fill, promote or evict as the policy says.
    function bit lookup_set(int unsigned base, int unsigned n, logic [TagW-1:0] tag);
      int unsigned i;
      for (i = 0; i < n; i++) begin
        if (!valid_bits[base+i]) begin
          tags[base+i] = tag;
          valid_bits[base+i] = 1'b1;
          return 1'b0;
        end
        if (tags[base+i] == tag) begin
          if (replace_lru) begin
            while (i + 1 < n && valid_bits[base+i+1]) begin
              tags[base+i] = tags[base+i+1];
              i++;
            end
            tags[base+i] = tag;
            valid_bits[base+i] = 1'b1;
          end
          return 1'b1;
        end
      end
      for (i = 1; i < n; i++) begin
        tags[base+i-1] = tags[base+i];
        valid_bits[base+i-1] = valid_bits[base+i];
      end
      tags[base+n-1] = tag;
      valid_bits[base+n-1] = 1'b1;
      return 1'b0;
    endfunction

    function void note_address(logic [AddrW-1:0] address);
      int unsigned nl, nw, base;
      logic [TagW-1:0] tag;
      lookup_result_t r;
      nl = (lines_log2 > MaxLinesLog2) ? MaxLinesLog2 : lines_log2;
      nw = (ways_log2 > nl) ? nl : ways_log2;
      tag = TagW'(address >> line_size_log2);
      base = int'(tag) & ((1 << nl) - 1) & ~((1 << nw) - 1);
      r.hit = lookup_set(base, 1 << nw, tag);
      if (r.hit) hits++;
      accesses++;
      r.hit_count = hits;
      r.access_count = accesses;
      pending.push_back(r);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hit=%0d hits=%0d acc=%0d, got hit=%0d hits=%0d acc=%0d",
                   exp.hit, exp.hit_count, exp.access_count,
                   got.hit, got.hit_count, got.access_count);
      end
    endfunction
  endclass
endpackage

// ===== test/set_assoc_cache_hit_model_unit_tb.sv =====
// Testbench top for set_assoc_cache_hit_model_unit: drives addresses through
// several geometries and idling phases, checks each result against a scoreboard.
// Depends on sacache_pkg, sacache_req_if, sacache_rsp_if, sacache_tb_pkg.
module set_assoc_cache_hit_model_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sacache_pkg::*;
  import sacache_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  sacache_req_if req ();
  sacache_rsp_if rsp ();

  set_assoc_cache_hit_model_unit dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hit_scoreboard board;
  int send_idle_pct = 0;     // chance in a hundred that the sender idles
  int stall_pct = 0;         // chance in a hundred that the receiver stalls
  int hold_off = 0;          // long receiver hold-off, in cycles
  longint unsigned cycles = 0;
  // Recent addresses, reused to provoke hits.
  logic [AddrW-1:0] recent [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.address = '0;
    rsp.ready = 1'b0;
  end

  // Watchdog: far above the slowest run (~700 items under receiver stall).
  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd1_500_000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: decide ready at the falling edge, sample at the rising edge.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    lookup_result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.hit = rsp.hit;
      got.hit_count = rsp.hit_count;
      got.access_count = rsp.access_count;
      board.check_result(got);
    end
  end

  // Offer one address and hold it until the transaction completes; valid stays
  // high afterwards so the next call can follow with no gap.
  task automatic send_address(logic [AddrW-1:0] address);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.address <= address;
    do @(posedge clk); while (!req.ready);
    board.note_address(address);
    recent.push_back(address);
    if (recent.size() > 24) void'(recent.pop_front());
    @(negedge clk);
  endtask

  // Drain: drop valid, wait for every expected result, then a latency margin.
  task automatic drain();
    req.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic set_geometry(int ln, int ls, int wy, int lru);
    write_reg(REG_LINES_LOG2, CfgDataW'(ln));
    write_reg(REG_LINE_SIZE_LOG2, CfgDataW'(ls));
    write_reg(REG_WAYS_LOG2, CfgDataW'(wy));
    write_reg(REG_REPLACE_LRU, CfgDataW'(lru));
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly revisits of a small working set, some wild addresses.
  task automatic random_burst(int n);
    logic [AddrW-1:0] a;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1:    a = $urandom();
        2, 3, 4: a = (recent.size() != 0) ? recent[$urandom_range(recent.size() - 1)]
                                          : $urandom();
        default: a = $urandom_range(4095) ^ (($urandom_range(3)) << 30);
      endcase
      send_address(a);
    end
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset geometry, address extremes, repeats for hits, eviction.
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0000);
    send_address(32'h8000_0000);
    send_address(32'h7FFF_FFFF);
    for (int k = 0; k < 10; k++) send_address(AddrW'(k) << 10);
    send_address(32'h0000_0000);
    send_address(32'h0000_0400);
    drain();

    // LRU with oversize lines_log2 and ways_log2 (clamped), tiny shifts.
    set_geometry(15, 0, 15, 1);
    for (int k = 0; k < 6; k++) send_address(AddrW'(k));
    send_address(32'h0000_0002);
    send_address(32'hAAAA_5555);
    drain();

    // Direct-mapped, single line, largest line size.
    set_geometry(0, 31, 0, 0);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0001);
    send_address(32'h8000_0000);
    drain();

    // Random phases across idling modes and geometries.
    for (int ph = 0; ph < 8; ph++) begin
      set_geometry($urandom_range(10), $urandom_range(31), $urandom_range(10),
                   $urandom_range(1));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      if (ph == 4) hold_off = 400;  // receiver holds off, block backs up
      random_burst(80);
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== set_assoc_cache_hit_model_unit.f =====
rtl/core/sacache_pkg.sv
rtl/core/sacache_req_if.sv
rtl/core/sacache_rsp_if.sv
rtl/core/sacache_ctrl.sv
rtl/core/sacache_dp.sv
rtl/core/set_assoc_cache_hit_model_unit.sv
test/sacache_tb_if.sv
test/set_assoc_cache_hit_model_unit_tb.sv
